// File: rtl/bls_pkg.sv
package bls_pkg;

  // bar geometry
  localparam int BAR_PIXELS = 44;
  localparam int POS_W      = $clog2(BAR_PIXELS + 1);

  // tick countdown
  localparam int          CNT_W   = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register limits
  localparam int COLOR_W   = 4;
  localparam int PCT_W     = 7;
  localparam int COLOR_MAX = 8;
  localparam int PCT_MIN   = 1;
  localparam int PCT_MAX   = 100;
  localparam int BPM_MIN   = 30;
  localparam int BPM_MAX   = 100;

  localparam logic [COLOR_W-1:0] COLOR_RST = COLOR_W'(0);
  localparam logic [PCT_W-1:0]   BRI_RST   = PCT_W'(50);
  localparam logic [PCT_W-1:0]   AMP_RST   = PCT_W'(50);
  localparam logic [PCT_W-1:0]   BPM_RST   = PCT_W'(60);

  // step period = STEP_NUM / (BAR_PIXELS * bpm)
  localparam int STEP_NUM = 61000000;
  localparam int NUM_W    = $clog2(STEP_NUM + 1);
  localparam int DIV_W    = $clog2(BAR_PIXELS * BPM_MAX + 1);
  localparam int DCNT_W   = $clog2(NUM_W + 1);

  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x below 2^15
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int BRI_K_W      = $clog2(PCT_MAX * DIV100_MUL + 1);
  localparam int CH_PROD_W    = 8 + BRI_K_W;
  localparam int LEN_MUL      = BAR_PIXELS * DIV100_MUL;
  localparam int LEN_PROD_W   = PCT_W + $clog2(LEN_MUL + 1);

  // config register map
  localparam int CFG_AW = 4;
  typedef enum logic [1:0] {
    REG_COLOR  = 2'd0,
    REG_BRIGHT = 2'd1,
    REG_AMP    = 2'd2,
    REG_BPM    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [PCT_W-1:0]   bright;
    logic [PCT_W-1:0]   amp;
    logic [PCT_W-1:0]   bpm;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_EMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic stop;       // blank frame, park position
    logic cnt_clear;
    logic cnt_dec;
    logic start;      // latch frame settings, start period divide
    logic scale;      // scale color channels
    logic pix_adv;
    logic finish;     // reload countdown, step position
  } dp_cmd_t;

  typedef struct packed {
    logic color_zero;
    logic cnt_zero;
    logic last_pix;
    logic dark;
    logic div_done;
  } dp_sts_t;

  function automatic rgb_t palette(input logic [COLOR_W-1:0] sel);
    rgb_t c;
    case (sel)
      COLOR_W'(1): c = '{8'd255, 8'd0,   8'd255};
      COLOR_W'(2): c = '{8'd0,   8'd0,   8'd255};
      COLOR_W'(3): c = '{8'd0,   8'd255, 8'd0};
      COLOR_W'(4): c = '{8'd0,   8'd255, 8'd255};
      COLOR_W'(5): c = '{8'd255, 8'd20,  8'd147};
      COLOR_W'(6): c = '{8'd255, 8'd128, 8'd0};
      COLOR_W'(7): c = '{8'd255, 8'd0,   8'd0};
      COLOR_W'(8): c = '{8'd255, 8'd180, 8'd80};
      default:     c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/bls_if.sv
interface bls_in_if;
  logic valid;
  logic ready;
  logic stop_request;

  modport source(output valid, output stop_request, input ready);
  modport sink(input valid, input stop_request, output ready);
endinterface

interface bls_out_if;
  import bls_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pixel_index;
  logic [7:0]       red;
  logic [7:0]       green;
  logic [7:0]       blue;
  logic             frame_end;

  modport source(output valid, output pixel_index, output red, output green, output blue,
                 output frame_end, input ready);
  modport sink(input valid, input pixel_index, input red, input green, input blue,
               input frame_end, output ready);
endinterface

// File: rtl/bouncing_led_bar_scanner.sv
// bouncing LED bar scanner
// in_ch: one beat per microsecond tick; stop_request blanks the bar and parks
// the position one past the end.
// out_ch: one beat per pixel, BAR_PIXELS beats per frame in pixel order,
// frame_end set on the last one.
// cfg_*: APB register port, color at 0x0, brightness 0x4, amplitude 0x8,
// bpm 0xc; write only while no frame is in flight.
// a tick with no frame leaves the controller idle, so ticks can arrive every
// cycle while no frame is in flight. a frame tick passes through ST_SCALE
// before its first pixel, a blank frame does not; then one pixel per cycle
// while out_ch is ready. the tick port reopens after ST_FINISH, which waits
// on the period divider running under the pixel stream (a blank frame skips it).
// stalls on out_ch hold the current pixel; no new tick is taken until the
// frame is fully delivered.
// reset: color 0 (only stop requests make frames), brightness 50, amplitude 50, 60 bpm, position
// parked, countdown zero so the first colored tick makes a frame.
module bouncing_led_bar_scanner (
  input  logic                        clk,
  input  logic                        rst_n,
  bls_in_if.sink                      in_ch,
  bls_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bls_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import bls_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  bls_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_stop   (in_ch.stop_request),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bls_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .pixel_index (out_ch.pixel_index),
    .red         (out_ch.red),
    .green       (out_ch.green),
    .blue        (out_ch.blue),
    .frame_end   (out_ch.frame_end)
  );

endmodule

// File: rtl/bls_cfg.sv
module bls_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bls_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output bls_pkg::cfg_t               cfg
);
  import bls_pkg::*;

  cfg_t     cfg_r;
  cfg_reg_t sel;
  logic     wr_en;

  assign sel        = cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color  <= COLOR_RST;
      cfg_r.bright <= BRI_RST;
      cfg_r.amp    <= AMP_RST;
      cfg_r.bpm    <= BPM_RST;
    end else if (wr_en) begin
      case (sel)
        REG_COLOR:  cfg_r.color  <= cfg_pwdata[COLOR_W-1:0];
        REG_BRIGHT: cfg_r.bright <= cfg_pwdata[PCT_W-1:0];
        REG_AMP:    cfg_r.amp    <= cfg_pwdata[PCT_W-1:0];
        REG_BPM:    cfg_r.bpm    <= cfg_pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_COLOR:  cfg_prdata = 32'(cfg_r.color);
      REG_BRIGHT: cfg_prdata = 32'(cfg_r.bright);
      REG_AMP:    cfg_prdata = 32'(cfg_r.amp);
      REG_BPM:    cfg_prdata = 32'(cfg_r.bpm);
      default:    cfg_prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/bls_ctrl.sv
module bls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stop,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bls_pkg::dp_sts_t  sts,
  output bls_pkg::dp_cmd_t  cmd
);
  import bls_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_stop) begin
            state_nxt = ST_EMIT;
          end else if (!sts.color_zero && sts.cnt_zero) begin
            state_nxt = ST_SCALE;
          end
        end
      end
      ST_SCALE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ready && sts.last_pix) begin
          state_nxt = sts.dark ? ST_IDLE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_stop) begin
            cmd.stop = 1'b1;
          end else if (sts.color_zero) begin
            cmd.cnt_clear = 1'b1;
          end else if (!sts.cnt_zero) begin
            cmd.cnt_dec = 1'b1;
          end else begin
            cmd.start = 1'b1;
          end
        end
      end
      ST_SCALE: cmd.scale = 1'b1;
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.pix_adv = out_ready;
      end
      ST_FINISH: cmd.finish = sts.div_done;
      default: ;
    endcase
  end

endmodule

// File: rtl/bls_dp.sv
module bls_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bls_pkg::cfg_t             cfg,
  input  bls_pkg::dp_cmd_t          cmd,
  output bls_pkg::dp_sts_t          sts,
  output logic [bls_pkg::POS_W-1:0] pixel_index,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic                      frame_end
);
  import bls_pkg::*;

  // sweep state
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               down_r, down_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [POS_W-1:0]   idx_r;
  logic               dark_r;

  // frame settings
  logic [POS_W-1:0]   len_r;
  logic [COLOR_W-1:0] sel_r;
  logic [BRI_K_W-1:0] bri_k_r;
  rgb_t               rgb_r;

  // period divider
  logic [DIV_W-1:0]   div_d_r;
  logic [DIV_W-1:0]   rem_r;
  logic [NUM_W-1:0]   quo_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic               busy_r;

  // clamped settings
  logic [COLOR_W-1:0]    sel_c;
  logic [PCT_W-1:0]      bri_c, amp_c, bpm_c;
  logic [LEN_PROD_W-1:0] len_prod;
  logic [LEN_PROD_W-1:0] len_q;
  logic [POS_W-1:0]      len_c;

  always_comb begin
    sel_c = (cfg.color > COLOR_W'(COLOR_MAX)) ? COLOR_W'(COLOR_MAX) : cfg.color;
    bri_c = cfg.bright;
    if (cfg.bright < PCT_W'(PCT_MIN)) bri_c = PCT_W'(PCT_MIN);
    if (cfg.bright > PCT_W'(PCT_MAX)) bri_c = PCT_W'(PCT_MAX);
    amp_c = cfg.amp;
    if (cfg.amp < PCT_W'(PCT_MIN)) amp_c = PCT_W'(PCT_MIN);
    if (cfg.amp > PCT_W'(PCT_MAX)) amp_c = PCT_W'(PCT_MAX);
    bpm_c = cfg.bpm;
    if (cfg.bpm < PCT_W'(BPM_MIN)) bpm_c = PCT_W'(BPM_MIN);
    if (cfg.bpm > PCT_W'(BPM_MAX)) bpm_c = PCT_W'(BPM_MAX);
  end

  // segment length = floor(BAR_PIXELS * amp / 100), clamped to 1..BAR_PIXELS
  assign len_prod = LEN_PROD_W'(amp_c) * LEN_PROD_W'(LEN_MUL);
  assign len_q    = len_prod >> DIV100_SHIFT;
  always_comb begin
    if (len_q < LEN_PROD_W'(1)) begin
      len_c = POS_W'(1);
    end else if (len_q > LEN_PROD_W'(BAR_PIXELS)) begin
      len_c = POS_W'(BAR_PIXELS);
    end else begin
      len_c = len_q[POS_W-1:0];
    end
  end

  // channel scaling: floor(ch * bri / 100) as ch * (bri * k) >> shift
  rgb_t                 pal;
  logic [CH_PROD_W-1:0] r_prod, g_prod, b_prod;
  logic [CH_PROD_W-1:0] r_q, g_q, b_q;

  assign pal    = palette(sel_r);
  assign r_prod = CH_PROD_W'(pal.red) * CH_PROD_W'(bri_k_r);
  assign g_prod = CH_PROD_W'(pal.green) * CH_PROD_W'(bri_k_r);
  assign b_prod = CH_PROD_W'(pal.blue) * CH_PROD_W'(bri_k_r);
  assign r_q    = r_prod >> DIV100_SHIFT;
  assign g_q    = g_prod >> DIV100_SHIFT;
  assign b_q    = b_prod >> DIV100_SHIFT;

  // restoring divider, one quotient bit a cycle
  logic [DIV_W:0] rem_sh;
  logic           q_bit;
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_d_r});

  // period saturated to 1..CNT_MAX, countdown reloads with period - 1
  logic [CNT_W-1:0] period;
  always_comb begin
    if (quo_r > NUM_W'(CNT_MAX)) begin
      period = CNT_MAX;
    end else if (quo_r == '0) begin
      period = CNT_W'(1);
    end else begin
      period = quo_r[CNT_W-1:0];
    end
  end

  // bounce step
  logic [POS_W:0] pos_wide;
  always_comb begin
    down_nxt = down_r;
    pos_wide = {1'b0, pos_r} + (POS_W+1)'(1);
    if (down_r) begin
      if (pos_r <= POS_W'(1)) begin
        pos_wide = '0;
        down_nxt = 1'b0;
      end else begin
        pos_wide = {1'b0, pos_r} - (POS_W+1)'(1);
      end
    end
    if (!(down_r && pos_r <= POS_W'(1)) && pos_wide >= (POS_W+1)'(BAR_PIXELS - 1)) begin
      pos_wide = (POS_W+1)'(BAR_PIXELS - 1);
      down_nxt = 1'b1;
    end
    pos_nxt = pos_wide[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_W'(BAR_PIXELS);
      down_r <= 1'b0;
      cnt_r  <= '0;
      idx_r  <= '0;
      dark_r <= 1'b0;
      busy_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      if (cmd.stop) begin
        pos_r  <= POS_W'(BAR_PIXELS);
        cnt_r  <= '0;
        idx_r  <= '0;
        dark_r <= 1'b1;
      end
      if (cmd.cnt_clear) begin
        cnt_r <= '0;
      end
      if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (cmd.start) begin
        idx_r  <= '0;
        dark_r <= 1'b0;
        busy_r <= 1'b1;
        dcnt_r <= DCNT_W'(NUM_W);
      end else if (busy_r) begin
        dcnt_r <= dcnt_r - DCNT_W'(1);
        if (dcnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
      if (cmd.pix_adv) begin
        idx_r <= idx_r + POS_W'(1);
      end
      if (cmd.finish) begin
        cnt_r  <= period - CNT_W'(1);
        pos_r  <= pos_nxt;
        down_r <= down_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      len_r   <= len_c;
      sel_r   <= sel_c;
      bri_k_r <= BRI_K_W'(bri_c) * BRI_K_W'(DIV100_MUL);
      div_d_r <= DIV_W'(BAR_PIXELS) * DIV_W'(bpm_c);
      rem_r   <= '0;
      quo_r   <= NUM_W'(STEP_NUM);
    end else if (busy_r) begin
      rem_r <= q_bit ? DIV_W'(rem_sh - {1'b0, div_d_r}) : rem_sh[DIV_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], q_bit};
    end
    if (cmd.scale) begin
      rgb_r.red   <= r_q[7:0];
      rgb_r.green <= g_q[7:0];
      rgb_r.blue  <= b_q[7:0];
    end
  end

  // parked position (one past the end) lights nothing, so a blank frame needs no mask
  logic lit;
  assign lit = (idx_r >= pos_r) && ((idx_r - pos_r) < len_r);

  assign pixel_index = idx_r;
  assign red         = lit ? rgb_r.red : 8'd0;
  assign green       = lit ? rgb_r.green : 8'd0;
  assign blue        = lit ? rgb_r.blue : 8'd0;
  assign frame_end   = (idx_r == POS_W'(BAR_PIXELS - 1));

  assign sts.color_zero = (cfg.color == '0);
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.last_pix   = frame_end;
  assign sts.dark       = dark_r;
  assign sts.div_done   = !busy_r;

endmodule
